@@ rtl/core/rtwe_pkg.sv @@
// Package for the route time-window evaluator.
// Holds widths, register indexes, sequencer state and control structs.
// No dependencies.
`timescale 1ns / 1ps

package rtwe_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DEMAND_W  = 12;
    localparam int SERVICE_W = 20;
    localparam int LOAD_W    = 20;
    localparam int CAP_W     = 16;
    localparam int COST_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DEPOT_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPOT_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SUM,
        ST_ROOT,
        ST_ARRIVE,
        ST_SERVE,
        ST_RET_DIFF,
        ST_COST
    } t_state;

    // sequencer strobes to the datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic mul_x;
        logic mul_y;
        logic sqrt_start;
        logic arrive;
        logic serve;
        logic ret_diff;
        logic cost_load;
    } t_ctrl;

    // datapath status to the sequencer
    typedef struct packed {
        logic in_valid;
        logic last;
        logic ret;
        logic sqrt_done;
        logic out_busy;
    } t_stat;

endpackage

@@ rtl/core/route_time_window_evaluator.sv @@
// Route time-window evaluator: capacity, time-window check and route cost.
// Sequence: each customer passes the squarer, the root unit, arrival and
// service before the next request is taken; the last one adds the depot
// return and cost, and its result waits while the output register stalls.
// Throughput: one request at a time; the shared multiplier and the bit-pair
// square root unit set the pace.
// Reset: synchronous active low; state reads zero, route starts at depot.
`timescale 1ns / 1ps

module route_time_window_evaluator #(
    parameter int COORD_WIDTH = rtwe_pkg::COORD_WIDTH_DEF,
    parameter int TIME_WIDTH  = rtwe_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [rtwe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rtwe_pkg::CFG_W-1:0]          i_cfg_data,
    // customer requests
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [COORD_WIDTH-1:0]              i_customer_x,
    input  logic [COORD_WIDTH-1:0]              i_customer_y,
    input  logic [rtwe_pkg::DEMAND_W-1:0]       i_customer_demand,
    input  logic [TIME_WIDTH-1:0]               i_ready_time,
    input  logic [TIME_WIDTH-1:0]               i_due_time,
    input  logic [rtwe_pkg::SERVICE_W-1:0]      i_service_duration,
    input  logic                                i_route_end,
    // route results
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rtwe_pkg::COST_W-1:0]         o_route_cost,
    output logic                                o_route_feasible
);

    localparam int CW     = COORD_WIDTH;
    localparam int TW     = TIME_WIDTH;
    localparam int ROOT_W = CW + 1;
    localparam int SQ_W   = 2 * CW + 1;
    localparam int MAX_A  = (TW > ROOT_W) ? TW : ROOT_W;
    localparam int MAX_B  = (MAX_A > rtwe_pkg::SERVICE_W) ? MAX_A : rtwe_pkg::SERVICE_W;
    localparam int MAX_C  = (MAX_B > rtwe_pkg::COST_W) ? MAX_B : rtwe_pkg::COST_W;
    localparam int SUM_W  = MAX_C + 1;
    localparam logic [SUM_W-1:0] TMAX    = {{(SUM_W-TW){1'b0}}, {TW{1'b1}}};
    localparam logic [SUM_W-1:0] OUT_MAX =
        {{(SUM_W-rtwe_pkg::COST_W){1'b0}}, {rtwe_pkg::COST_W{1'b1}}};
    localparam logic [rtwe_pkg::LOAD_W:0] LOAD_MAX = {1'b0, {rtwe_pkg::LOAD_W{1'b1}}};

    rtwe_pkg::t_ctrl ctrl;
    rtwe_pkg::t_stat stat;

    // configuration registers
    logic [rtwe_pkg::CFG_W-1:0] r_depot_x;
    logic [rtwe_pkg::CFG_W-1:0] r_depot_y;
    logic [rtwe_pkg::CAP_W-1:0] r_capacity;

    // route state
    logic                        r_open;
    logic [CW-1:0]               r_prev_x;
    logic [CW-1:0]               r_prev_y;
    logic [rtwe_pkg::LOAD_W-1:0] r_load;
    logic [TW-1:0]               r_elapsed;
    logic                        r_failed;
    logic                        r_ret;

    // per-request operands and intermediates
    logic [TW-1:0]                  r_ready;
    logic [TW-1:0]                  r_due;
    logic [rtwe_pkg::SERVICE_W-1:0] r_service;
    logic                           r_last;
    logic [CW-1:0]                  r_dx;
    logic [CW-1:0]                  r_dy;
    logic [2*CW-1:0]                r_sqx;
    logic [2*CW-1:0]                r_sqy;
    logic [TW-1:0]                  r_arrival;

    // output register
    logic                        r_out_valid;
    logic [rtwe_pkg::COST_W-1:0] r_out_cost;
    logic                        r_out_feasible;

    logic [CW-1:0]             depot_cx;
    logic [CW-1:0]             depot_cy;
    logic [CW-1:0]             from_x;
    logic [CW-1:0]             from_y;
    logic [CW-1:0]             to_x;
    logic [CW-1:0]             to_y;
    logic [CW-1:0]             diff_x;
    logic [CW-1:0]             diff_y;
    logic [CW-1:0]             mul_op;
    logic [2*CW-1:0]           product;
    logic [SQ_W-1:0]           radicand;
    logic                      sqrt_busy;
    logic                      sqrt_done;
    logic [ROOT_W-1:0]         root;
    logic [rtwe_pkg::LOAD_W:0] load_sum;
    logic [rtwe_pkg::LOAD_W-1:0] load_sat;
    logic [SUM_W-1:0]          travel_sum;
    logic [TW-1:0]             travel_sat;
    logic [TW-1:0]             begin_time;
    logic [SUM_W-1:0]          serve_sum;
    logic [TW-1:0]             serve_sat;
    logic [SUM_W-1:0]          cost_wide;
    logic [rtwe_pkg::COST_W-1:0] cost_cap;

    rtwe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    rtwe_sqrt #(
        .COORD_WIDTH (CW)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.sqrt_start),
        .i_radicand (radicand),
        .o_busy     (sqrt_busy),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    always_comb begin
        stat.in_valid  = i_in_valid;
        stat.last      = r_last;
        stat.ret       = r_ret;
        stat.sqrt_done = sqrt_done;
        stat.out_busy  = r_out_valid && i_out_stall;
    end

    // depot registers seen at coordinate width
    assign depot_cx = CW'(r_depot_x);
    assign depot_cy = CW'(r_depot_y);

    // one absolute-difference pair, shared by the leg and the depot return
    always_comb begin
        if (ctrl.ret_diff) begin
            from_x = r_prev_x;
            from_y = r_prev_y;
            to_x   = depot_cx;
            to_y   = depot_cy;
        end else begin
            from_x = r_open ? r_prev_x : depot_cx;
            from_y = r_open ? r_prev_y : depot_cy;
            to_x   = i_customer_x;
            to_y   = i_customer_y;
        end
        diff_x = (from_x > to_x) ? (from_x - to_x) : (to_x - from_x);
        diff_y = (from_y > to_y) ? (from_y - to_y) : (to_y - from_y);
    end

    // one shared squarer
    assign mul_op   = ctrl.mul_y ? r_dy : r_dx;
    assign product  = (2*CW)'(mul_op) * (2*CW)'(mul_op);
    assign radicand = SQ_W'(r_sqx) + SQ_W'(r_sqy);

    always_comb begin
        load_sum = {1'b0, r_load} + (rtwe_pkg::LOAD_W+1)'(i_customer_demand);
        load_sat = (load_sum > LOAD_MAX) ? rtwe_pkg::LOAD_W'(LOAD_MAX)
                                         : load_sum[rtwe_pkg::LOAD_W-1:0];

        travel_sum = SUM_W'(r_elapsed) + SUM_W'(root);
        travel_sat = (travel_sum > TMAX) ? TW'(TMAX) : travel_sum[TW-1:0];

        begin_time = (r_ready > r_arrival) ? r_ready : r_arrival;
        serve_sum  = SUM_W'(begin_time) + SUM_W'(r_service);
        serve_sat  = (serve_sum > TMAX) ? TW'(TMAX) : serve_sum[TW-1:0];

        cost_wide = SUM_W'(travel_sat);
        cost_cap  = (cost_wide > OUT_MAX) ? OUT_MAX[rtwe_pkg::COST_W-1:0]
                                          : cost_wide[rtwe_pkg::COST_W-1:0];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depot_x  <= '0;
            r_depot_y  <= '0;
            r_capacity <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rtwe_pkg::REG_DEPOT_X:  r_depot_x  <= i_cfg_data;
                rtwe_pkg::REG_DEPOT_Y:  r_depot_y  <= i_cfg_data;
                rtwe_pkg::REG_CAPACITY: r_capacity <= rtwe_pkg::CAP_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // route state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_load    <= '0;
            r_elapsed <= '0;
            r_failed  <= 1'b0;
            r_ret     <= 1'b0;
        end else if (ctrl.cost_load) begin
            // rearm for a new route at the depot
            r_open    <= 1'b0;
            r_load    <= '0;
            r_elapsed <= '0;
            r_failed  <= 1'b0;
            r_ret     <= 1'b0;
        end else begin
            if (ctrl.accept) begin
                r_open <= 1'b1;
                r_load <= load_sat;
                if (rtwe_pkg::LOAD_W'(load_sat) > rtwe_pkg::LOAD_W'(r_capacity)) begin
                    r_failed <= 1'b1;
                end
            end
            if (ctrl.arrive && (travel_sat > r_due)) begin
                r_failed <= 1'b1;
            end
            if (ctrl.serve) begin
                r_elapsed <= serve_sat;
            end
            if (ctrl.ret_diff) begin
                r_ret <= 1'b1;
            end
        end
    end

    // operand and intermediate registers
    always_ff @(posedge i_clk) begin
        if (ctrl.accept) begin
            r_prev_x  <= i_customer_x;
            r_prev_y  <= i_customer_y;
            r_ready   <= i_ready_time;
            r_due     <= i_due_time;
            r_service <= i_service_duration;
            r_last    <= i_route_end;
        end
        if (ctrl.accept || ctrl.ret_diff) begin
            r_dx <= diff_x;
            r_dy <= diff_y;
        end
        if (ctrl.mul_x) r_sqx <= product;
        if (ctrl.mul_y) r_sqy <= product;
        if (ctrl.arrive) r_arrival <= travel_sat;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.cost_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.cost_load) begin
            r_out_cost     <= r_failed ? '0 : cost_cap;
            r_out_feasible <= !r_failed;
        end
    end

    assign o_in_stall       = !ctrl.in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_route_cost     = r_out_cost;
    assign o_route_feasible = r_out_feasible;

    a_sqrt_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.sqrt_start |-> !sqrt_busy)
        else $error("root started while root unit busy");

    a_result_from_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctrl.cost_load))
        else $error("result shown without cost step");

    a_cost_on_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.cost_load |-> (r_ret && !(r_out_valid && i_out_stall)))
        else $error("cost loaded outside depot return or over a held result");

    a_route_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_open && o_in_stall))
        else $error("accepted request did not open the route");

endmodule

@@ rtl/core/rtwe_sqrt.sv @@
// Iterative integer square root, one radicand bit pair per cycle.
// Returns floor(sqrt(radicand)); depends on nothing outside this file.
`timescale 1ns / 1ps

module rtwe_sqrt #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [2*COORD_WIDTH:0]   i_radicand,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [COORD_WIDTH:0]     o_root
);

    localparam int PAIRS  = COORD_WIDTH + 1;
    localparam int RAD_W  = 2 * PAIRS;
    localparam int ROOT_W = COORD_WIDTH + 1;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(PAIRS + 1);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    // bring down the next pair and try root*4+1 against it
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root[REM_W-3:0], 2'b01};
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PAIRS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RAD_W'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= take ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], take};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ rtl/core/rtwe_ctrl.sv @@
// Sequencer of the route time-window evaluator.
// Steps requests via multiply, root, time and depot cost; uses rtwe_pkg.
`timescale 1ns / 1ps

module rtwe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rtwe_pkg::t_stat i_stat,
    output rtwe_pkg::t_ctrl o_ctrl
);

    rtwe_pkg::t_state r_state;
    rtwe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtwe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtwe_pkg::ST_IDLE: begin
                if (i_stat.in_valid) n_state = rtwe_pkg::ST_MUL_X;
            end
            rtwe_pkg::ST_MUL_X:    n_state = rtwe_pkg::ST_MUL_Y;
            rtwe_pkg::ST_MUL_Y:    n_state = rtwe_pkg::ST_SUM;
            rtwe_pkg::ST_SUM:      n_state = rtwe_pkg::ST_ROOT;
            rtwe_pkg::ST_ROOT: begin
                if (i_stat.sqrt_done) begin
                    n_state = i_stat.ret ? rtwe_pkg::ST_COST : rtwe_pkg::ST_ARRIVE;
                end
            end
            rtwe_pkg::ST_ARRIVE:   n_state = rtwe_pkg::ST_SERVE;
            rtwe_pkg::ST_SERVE: begin
                n_state = i_stat.last ? rtwe_pkg::ST_RET_DIFF : rtwe_pkg::ST_IDLE;
            end
            rtwe_pkg::ST_RET_DIFF: n_state = rtwe_pkg::ST_MUL_X;
            rtwe_pkg::ST_COST: begin
                // hold the result until the output register is free
                if (!i_stat.out_busy) n_state = rtwe_pkg::ST_IDLE;
            end
            default:               n_state = rtwe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            rtwe_pkg::ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.accept   = i_stat.in_valid;
            end
            rtwe_pkg::ST_MUL_X:    o_ctrl.mul_x      = 1'b1;
            rtwe_pkg::ST_MUL_Y:    o_ctrl.mul_y      = 1'b1;
            rtwe_pkg::ST_SUM:      o_ctrl.sqrt_start = 1'b1;
            rtwe_pkg::ST_ROOT:     o_ctrl            = '0;
            rtwe_pkg::ST_ARRIVE:   o_ctrl.arrive     = 1'b1;
            rtwe_pkg::ST_SERVE:    o_ctrl.serve      = 1'b1;
            rtwe_pkg::ST_RET_DIFF: o_ctrl.ret_diff   = 1'b1;
            rtwe_pkg::ST_COST:     o_ctrl.cost_load  = !i_stat.out_busy;
            default:               o_ctrl            = '0;
        endcase
    end

endmodule
